/* rtl/ubd_pkg.sv */
// Shared types and constants for the UART baud divisor calculator.
package ubd_pkg;

  localparam int CLK_W   = 28;
  localparam int BAUD_W  = 17;
  localparam int WORD_W  = 16;
  localparam int NUM_W   = 33;
  localparam int DEN_W   = 19;
  localparam int QUO_W   = 22;
  localparam int STEP_PER_STAGE = 2;
  localparam int DIV_STAGES = QUO_W / STEP_PER_STAGE;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_FAST_CLK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOW_CLK = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OSR8     = 2'd2;

  localparam logic [CLK_W-1:0]  FAST_CLK_RST = 28'd72000000;
  localparam logic [CLK_W-1:0]  SLOW_CLK_RST = 28'd36000000;
  localparam logic [BAUD_W-1:0] BAUD_MIN     = 17'd1200;
  localparam logic [BAUD_W-1:0] BAUD_MAX     = 17'd115200;
  localparam logic [NUM_W-1:0]  CLK_SCALE    = 33'd25;

  // floor(q/100) = (q * RECIP_BIG) >> RECIP_BIG_SH for q < 2**22
  localparam logic [22:0] RECIP_BIG    = 23'd5368710;
  localparam int          RECIP_BIG_SH = 29;
  localparam int          PROD_BIG_W   = QUO_W + 23;
  localparam int          MANT_W       = PROD_BIG_W - RECIP_BIG_SH;
  localparam logic [QUO_W-1:0] HUNDRED = 22'd100;

  // floor(x/100) = (x * RECIP_SMALL) >> RECIP_SMALL_SH for x < 2**11
  localparam int          FRX_W          = 11;
  localparam logic [10:0] RECIP_SMALL    = 11'd1311;
  localparam int          RECIP_SMALL_SH = 17;
  localparam int          PROD_SMALL_W   = 22;
  localparam logic [FRX_W-1:0] ROUND_HALF = 11'd50;

  typedef struct packed {
    logic ok;
    logic by8;
  } ubd_side_t;

endpackage

/* rtl/ubd_div_pipe.sv */
// Pipelined restoring divider, two quotient bits per stage, with sideband.
module ubd_div_pipe import ubd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [NUM_W-1:0] in_num,
  input  logic [DEN_W-1:0] in_den,
  input  ubd_side_t        in_side,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [QUO_W-1:0] out_quo,
  output ubd_side_t        out_side
);

  logic [DIV_STAGES-1:0] v_r;
  logic [DIV_STAGES:0]   rdy;
  logic [DEN_W-1:0]      rem_r [DIV_STAGES];
  logic [QUO_W-1:0]      wrd_r [DIV_STAGES];
  logic [DEN_W-1:0]      den_r [DIV_STAGES];
  ubd_side_t             side_r [DIV_STAGES];

  assign rdy[DIV_STAGES] = out_ready;
  assign in_ready        = rdy[0];

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stg
    logic             v_in;
    logic [DEN_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [QUO_W-1:0] wrd_in;
    ubd_side_t        side_in;
    logic [DEN_W-1:0] rem_nxt;
    logic [QUO_W-1:0] wrd_nxt;
    logic [DEN_W:0]   ext;

    if (g == 0) begin : g_first
      // quotient fits QUO_W bits, so the top dividend bits start below the divisor
      assign v_in    = in_valid;
      assign rem_in  = DEN_W'(in_num[NUM_W-1:QUO_W]);
      assign wrd_in  = in_num[QUO_W-1:0];
      assign den_in  = in_den;
      assign side_in = in_side;
    end else begin : g_rest
      assign v_in    = v_r[g-1];
      assign rem_in  = rem_r[g-1];
      assign wrd_in  = wrd_r[g-1];
      assign den_in  = den_r[g-1];
      assign side_in = side_r[g-1];
    end

    // dividend bits shift out the top of wrd while quotient bits shift in below
    always_comb begin
      rem_nxt = rem_in;
      wrd_nxt = wrd_in;
      ext     = '0;
      for (int j = 0; j < STEP_PER_STAGE; j++) begin
        ext = {rem_nxt, wrd_nxt[QUO_W-1]};
        if (ext >= {1'b0, den_in}) begin
          rem_nxt = DEN_W'(ext - {1'b0, den_in});
          wrd_nxt = {wrd_nxt[QUO_W-2:0], 1'b1};
        end else begin
          rem_nxt = ext[DEN_W-1:0];
          wrd_nxt = {wrd_nxt[QUO_W-2:0], 1'b0};
        end
      end
    end

    assign rdy[g] = ~v_r[g] | rdy[g+1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g] <= 1'b0;
      end else if (rdy[g]) begin
        v_r[g] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[g]) begin
        rem_r[g]  <= rem_nxt;
        wrd_r[g]  <= wrd_nxt;
        den_r[g]  <= den_in;
        side_r[g] <= side_in;
      end
    end
  end

  assign out_valid = v_r[DIV_STAGES-1];
  assign out_quo   = wrd_r[DIV_STAGES-1];
  assign out_side  = side_r[DIV_STAGES-1];

endmodule

/* rtl/uart_baud_divisor_calc_core.sv */
// Top level of the UART fractional baud divisor calculator.
//
// channel | dir | handshake                | payload
// in_     | in  | in_tvalid / in_tready    | tdata: requested_baud, tuser: on_fast_bus
// out_    | out | out_tvalid / out_tready  | tdata: divisor_word, tuser: accepted
// cfg_    | in  | cfg_we (no back-pressure)| cfg_index, cfg_wdata
//
// One request per cycle while out_tready does not stall the pipeline; stages: input stage,
// 11 divider stages (two quotient bits each), and 4 stages for the /100 split, fraction rounding
// and output register.
// Reset (rst_n low, synchronous) empties the pipeline and loads register defaults.
// Each stage holds on a stall only while it is full; bubbles are squeezed out.
module uart_baud_divisor_calc_core import ubd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [23:0]          in_tdata,   // [16:0] requested_baud
  input  logic [0:0]           in_tuser,   // [0] on_fast_bus
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [15:0]          out_tdata,  // [15:0] divisor_word
  output logic [0:0]           out_tuser,  // [0] accepted
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CLK_W-1:0]     cfg_wdata
);

  logic [CLK_W-1:0] fast_clk_r;
  logic [CLK_W-1:0] slow_clk_r;
  logic             osr8_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fast_clk_r <= FAST_CLK_RST;
      slow_clk_r <= SLOW_CLK_RST;
      osr8_r     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FAST_CLK: fast_clk_r <= cfg_wdata;
        REG_SLOW_CLK: slow_clk_r <= cfg_wdata;
        REG_OSR8:     osr8_r     <= cfg_wdata[0];
        default:      ;
      endcase
    end
  end

  // input stage
  logic [BAUD_W-1:0] baud;
  logic [CLK_W-1:0]  clk_sel;
  logic [NUM_W-1:0]  num_nxt;
  logic [DEN_W-1:0]  den_nxt;
  ubd_side_t         side_nxt;

  assign baud         = in_tdata[BAUD_W-1:0];
  assign clk_sel      = in_tuser[0] ? fast_clk_r : slow_clk_r;
  assign num_nxt      = NUM_W'(clk_sel) * CLK_SCALE;
  assign den_nxt      = osr8_r ? {1'b0, baud, 1'b0} : {baud, 2'b00};
  assign side_nxt.ok  = (baud >= BAUD_MIN) && (baud <= BAUD_MAX);
  assign side_nxt.by8 = osr8_r;

  logic             va_r;
  logic [NUM_W-1:0] num_r;
  logic [DEN_W-1:0] den_r;
  ubd_side_t        side_a_r;
  logic             rdy_a;
  logic             div_in_ready;

  logic             div_valid;
  logic [QUO_W-1:0] div_quo;
  ubd_side_t        div_side;

  logic vp1_r, vp2_r, vp3_r, vo_r;
  logic rdy_p1, rdy_p2, rdy_p3, rdy_o;

  assign rdy_o     = ~vo_r  | out_tready;
  assign rdy_p3    = ~vp3_r | rdy_o;
  assign rdy_p2    = ~vp2_r | rdy_p3;
  assign rdy_p1    = ~vp1_r | rdy_p2;
  assign rdy_a     = ~va_r  | div_in_ready;
  assign in_tready = rdy_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (rdy_a) begin
      va_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a) begin
      num_r    <= num_nxt;
      den_r    <= den_nxt;
      side_a_r <= side_nxt;
    end
  end

  ubd_div_pipe u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (va_r),
    .in_ready  (div_in_ready),
    .in_num    (num_r),
    .in_den    (den_r),
    .in_side   (side_a_r),
    .out_valid (div_valid),
    .out_ready (rdy_p1),
    .out_quo   (div_quo),
    .out_side  (div_side)
  );

  // p1: reciprocal product for /100
  logic [PROD_BIG_W-1:0] prod_big_r;
  logic [QUO_W-1:0]      quo_p1_r;
  ubd_side_t             side_p1_r;

  // p2: mantissa and remainder
  logic [MANT_W-1:0] mant_p2_r;
  logic [6:0]        frac_p2_r;
  ubd_side_t         side_p2_r;
  logic [MANT_W-1:0] mant_nxt;
  logic [QUO_W-1:0]  frac_full;

  assign mant_nxt  = prod_big_r[PROD_BIG_W-1:RECIP_BIG_SH];
  assign frac_full = quo_p1_r - QUO_W'(QUO_W'(mant_nxt) * HUNDRED);

  // p3: rounded fraction product
  logic [PROD_SMALL_W-1:0] prod_small_r;
  logic [11:0]             mant_p3_r;
  ubd_side_t               side_p3_r;
  logic [FRX_W-1:0]        frx;

  assign frx = side_p2_r.by8 ? (FRX_W'({frac_p2_r, 3'b000}) + ROUND_HALF)
                             : (FRX_W'({frac_p2_r, 4'b0000}) + ROUND_HALF);

  // output
  logic [4:0]        frac_rnd;
  logic [3:0]        frac_bits;
  logic [WORD_W-1:0] word_nxt;
  logic [WORD_W-1:0] word_r;
  logic              acc_r;

  assign frac_rnd  = prod_small_r[PROD_SMALL_W-1:RECIP_SMALL_SH];
  assign frac_bits = side_p3_r.by8 ? {1'b0, frac_rnd[2:0]} : frac_rnd[3:0];
  assign word_nxt  = side_p3_r.ok ? {mant_p3_r, frac_bits} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vp1_r <= 1'b0;
      vp2_r <= 1'b0;
      vp3_r <= 1'b0;
      vo_r  <= 1'b0;
    end else begin
      if (rdy_p1) vp1_r <= div_valid;
      if (rdy_p2) vp2_r <= vp1_r;
      if (rdy_p3) vp3_r <= vp2_r;
      if (rdy_o)  vo_r  <= vp3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_p1) begin
      prod_big_r <= PROD_BIG_W'(div_quo) * PROD_BIG_W'(RECIP_BIG);
      quo_p1_r   <= div_quo;
      side_p1_r  <= div_side;
    end
    if (rdy_p2) begin
      mant_p2_r <= mant_nxt;
      frac_p2_r <= frac_full[6:0];
      side_p2_r <= side_p1_r;
    end
    if (rdy_p3) begin
      prod_small_r <= PROD_SMALL_W'(frx) * PROD_SMALL_W'(RECIP_SMALL);
      mant_p3_r    <= mant_p2_r[11:0];
      side_p3_r    <= side_p2_r;
    end
    if (rdy_o) begin
      word_r <= word_nxt;
      acc_r  <= side_p3_r.ok;
    end
  end

  assign out_tvalid   = vo_r;
  assign out_tdata    = word_r;
  assign out_tuser[0] = acc_r;

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == '0)
    else $error("rejected request with nonzero divisor");

  a_osr8_bit3: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && osr8_r && $stable(osr8_r) && $past(osr8_r, 16) && out_tuser[0]
      |-> !out_tdata[3])
    else $error("8x fraction spilled into bit 3");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without output back-pressure");

endmodule

/* tb/tb_uart_baud_divisor_calc_core.sv */
// Self-checking testbench for the UART fractional baud divisor calculator core.
module tb_uart_baud_divisor_calc_core;
  import ubd_pkg::*;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              ok;
  } baud_div_t;

  localparam longint unsigned SCALE_NUM = 25;
  localparam longint unsigned HUNDREDTHS = 100;
  localparam longint unsigned ROUND_UP = 50;
  localparam logic [CLK_W-1:0] CLK_ALL_ONES = {CLK_W{1'b1}};
  localparam logic [CLK_W-1:0] CLK_TOP = 28'd150000000;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [23:0]          in_tdata = '0;     // [16:0] requested_baud
  logic [0:0]           in_tuser = '0;     // [0] on_fast_bus
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [15:0]          out_tdata;         // [15:0] divisor_word
  logic [0:0]           out_tuser;         // [0] accepted
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CLK_W-1:0]     cfg_wdata = '0;

  // shadow of the block's registers
  logic [CLK_W-1:0] fast_hz = FAST_CLK_RST;
  logic [CLK_W-1:0] slow_hz = SLOW_CLK_RST;
  logic             osr8 = 1'b0;

  baud_div_t   pending_divisors[$];
  int unsigned burst_left = 0;
  int unsigned n_requests = 0;
  int unsigned n_results = 0;
  int unsigned n_in_range = 0;
  int unsigned n_settings = 0;
  int unsigned n_fail = 0;

  int unsigned ready_mode = 0;
  int unsigned ready_left = 0;
  int unsigned ready_phase = 0;
  logic [15:0] ready_mask = '1;

  uart_baud_divisor_calc_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #4 clk = ~clk;

  function automatic baud_div_t calc_divisor_word(input logic [BAUD_W-1:0] baud,
                                                  input logic fast);
    longint unsigned clk_hz, k, scaled, mant, frac, word;
    baud_div_t r;
    r = '0;
    if (baud < BAUD_MIN || baud > BAUD_MAX) return r;
    clk_hz = fast ? fast_hz : slow_hz;
    k = osr8 ? 2 : 4;
    scaled = (SCALE_NUM * clk_hz) / (k * baud);
    mant = scaled / HUNDREDTHS;
    frac = scaled - HUNDREDTHS * mant;
    word = mant << 4;
    if (osr8)
      word |= ((frac * 8 + ROUND_UP) / HUNDREDTHS) & 64'h7;
    else
      word |= ((frac * 16 + ROUND_UP) / HUNDREDTHS) & 64'hF;
    r.word = word[WORD_W-1:0];
    r.ok = 1'b1;
    return r;
  endfunction

  function automatic logic [BAUD_W-1:0] rand_baud();
    int unsigned std_rates[8] = '{1200, 2400, 4800, 9600, 19200, 38400, 57600, 115200};
    int unsigned edges[8] = '{0, 1199, 1200, 1201, 115199, 115200, 115201, 131071};
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick <= 5) return BAUD_W'($urandom_range(BAUD_MIN, BAUD_MAX));
    if (pick == 6) return BAUD_W'(std_rates[$urandom_range(0, 7)]);
    if (pick == 7) return BAUD_W'(edges[$urandom_range(0, 7)]);
    return BAUD_W'($urandom_range(0, 2**BAUD_W - 1));
  endfunction

  function automatic logic [CLK_W-1:0] rand_clock();
    int unsigned typical[8] = '{8000000, 16000000, 36000000, 42000000,
                                48000000, 72000000, 84000000, 150000000};
    int unsigned pick;
    pick = $urandom_range(0, 7);
    if (pick <= 3) return CLK_W'(typical[$urandom_range(0, 7)]);
    if (pick == 4) begin
      case ($urandom_range(0, 3))
        0: return '0;
        1: return CLK_W'(1);
        2: return CLK_TOP;
        default: return CLK_ALL_ONES;
      endcase
    end
    if (pick == 5) return CLK_W'($urandom_range(0, 2**CLK_W - 1));
    return CLK_W'($urandom_range(1, CLK_TOP));
  endfunction

  // receiver: ready pattern is redrawn whenever its random run counter runs out
  always @(negedge clk) begin
    if (ready_left == 0) begin
      ready_mode = $urandom_range(0, 3);
      ready_left = $urandom_range(20, 300);
      ready_mask = 16'($urandom);
      ready_mask[0] = 1'b1;
    end else begin
      ready_left--;
    end
    case (ready_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 3) != 0);
      2: out_tready <= ready_mask[ready_phase[3:0]];
      default: out_tready <= 1'($urandom_range(0, 1));
    endcase
    ready_phase++;
  end

  always @(posedge clk) begin
    baud_div_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_divisors.size() == 0) begin
        if (n_fail < 10)
          $display("unexpected result: word %h accepted %b", out_tdata, out_tuser[0]);
        n_fail++;
      end else begin
        want = pending_divisors.pop_front();
        n_results++;
        if (want.ok) n_in_range++;
        if (out_tdata !== want.word || out_tuser[0] !== want.ok) begin
          if (n_fail < 10)
            $display("mismatch: expected word %h accepted %b, got word %h accepted %b",
                     want.word, want.ok, out_tdata, out_tuser[0]);
          n_fail++;
        end
      end
    end
  end

  task automatic send_request(input logic [BAUD_W-1:0] baud, input logic fast);
    int unsigned gap;
    @(negedge clk);
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 20);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata <= {{(24-BAUD_W){1'b0}}, baud};
    in_tuser <= fast;
    do @(posedge clk); while (!in_tready);
    pending_divisors.push_back(calc_divisor_word(baud, fast));
    n_requests++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_divisors.size() != 0) @(posedge clk);
  endtask

  // block must be idle when called
  task automatic set_config(input logic [CLK_W-1:0] fast_clk,
                            input logic [CLK_W-1:0] slow_clk, input logic by8);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_FAST_CLK;
    cfg_wdata <= fast_clk;
    fast_hz = fast_clk;
    @(negedge clk);
    cfg_index <= REG_SLOW_CLK;
    cfg_wdata <= slow_clk;
    slow_hz = slow_clk;
    @(negedge clk);
    cfg_index <= REG_OSR8;
    cfg_wdata <= {{(CLK_W-1){1'b0}}, by8};
    osr8 = by8;
    @(negedge clk);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  // reset defaults, rate limits and out-of-range rates
  task automatic test_range_edges();
    send_request(17'd1200, 1'b1);
    send_request(17'd1200, 1'b0);
    send_request(17'd115200, 1'b1);
    send_request(17'd115200, 1'b0);
    send_request(17'd1199, 1'b1);
    send_request(17'd115201, 1'b0);
    send_request(17'd0, 1'b1);
    send_request(17'd131071, 1'b0);
    send_request(17'd9600, 1'b1);
    send_request(17'd65536, 1'b0);
    wait_idle();
  endtask

  // 8x mode, zero clock, mantissa truncation, fraction wrap without carry
  task automatic test_clock_extremes();
    set_config(CLK_ALL_ONES, '0, 1'b1);
    send_request(17'd1200, 1'b1);
    send_request(17'd1200, 1'b0);
    send_request(17'd115200, 1'b1);
    send_request(17'd57600, 1'b0);
    wait_idle();
    set_config(28'd1, CLK_TOP, 1'b0);
    send_request(17'd1200, 1'b1);
    send_request(17'd115200, 1'b0);
    send_request(17'd1201, 1'b0);
    send_request(17'd76800, 1'b0);
    send_request(17'd2400, 1'b1);
    wait_idle();
  endtask

  task automatic test_random_sweep();
    for (int p = 0; p < 8; p++) begin
      set_config(rand_clock(), rand_clock(), 1'($urandom_range(0, 1)));
      for (int i = 0; i < 175; i++) send_request(rand_baud(), 1'($urandom_range(0, 1)));
      wait_idle();
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_range_edges();
    test_clock_extremes();
    test_random_sweep();
    wait_idle();
    repeat (32) @(posedge clk);
    $display("covered %0d requests and %0d results (%0d in range, %0d rejected)",
             n_requests, n_results, n_in_range, n_results - n_in_range);
    $display("over %0d register settings, %0d failures", n_settings, n_fail);
    if (n_fail == 0 && pending_divisors.size() == 0)
      $display("uart_baud_divisor_calc_core regression: pass");
    else
      $display("uart_baud_divisor_calc_core regression: fail");
    $finish;
  end

  initial begin
    #4000000;
    $display("timeout with %0d results outstanding", pending_divisors.size());
    $display("uart_baud_divisor_calc_core regression: fail");
    $finish;
  end

endmodule

/* files.f */
rtl/ubd_pkg.sv
rtl/ubd_div_pipe.sv
rtl/uart_baud_divisor_calc_core.sv
tb/tb_uart_baud_divisor_calc_core.sv
